### hdl/smdl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo modulated delay line: shared package
// Holds the fixed field widths, register indexes, the command bundle from the
// controller to the datapath and the quarter-wave sine function that builds
// the LFO table at elaboration.
// ----------------------------------------------------------------------------
package smdl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CFG_W     = 20;
  localparam int PHASE_W   = 16;
  localparam int SINE_W    = 16;
  localparam int CFG_IDX_W = 2;
  // Signed width for the unclamped delay sum, enough for the deepest store.
  localparam int DCALC_W   = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;
  localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;

  typedef struct packed {
    logic accept;
    logic mul;
    logic dly;
    logic pos;
    logic rd0;
    logic rd1;
    logic intp;
    logic done;
  } cmd_t;

  // Sine of x (Q2.30, first quadrant) as a nine-term Taylor series, rounded
  // to Q1.15 magnitude.
  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x2  = (x * x) >> 30;
    t   = x;
    sum = signed'(x);
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd110;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd156;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd210;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd272;
    sum = sum + signed'(t);
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

### hdl/smdl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo modulated delay line: controller
// Steps each accepted request through delay calculation, the two store reads
// and interpolation, and owns the output valid flag.
// ----------------------------------------------------------------------------
module smdl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output smdl_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DLY  = 3'd2;
  localparam logic [2:0] ST_POS  = 3'd3;
  localparam logic [2:0] ST_RD0  = 3'd4;
  localparam logic [2:0] ST_RD1  = 3'd5;
  localparam logic [2:0] ST_INTP = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DLY;
      end
      ST_DLY: begin
        cmd.dly    = 1'b1;
        state_next = ST_POS;
      end
      ST_POS: begin
        cmd.pos    = 1'b1;
        state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd0    = 1'b1;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = ST_INTP;
      end
      ST_INTP: begin
        cmd.intp   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // The output register may only be reloaded once it is free.
        if (!out_valid || !out_stall) begin
          cmd.done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.done) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### hdl/smdl_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo modulated delay line: channel lane
// One channel's circular sample store (single port) with the linear
// interpolator and the saturating output register.
// ----------------------------------------------------------------------------
module smdl_lane #(
  parameter  int DELAY_DEPTH = 4096,
  localparam int AW          = $clog2(DELAY_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [smdl_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  input  wire logic                          cap_s0,
  input  wire logic                          v0,
  input  wire logic                          cap_s1,
  input  wire logic                          v1,
  input  wire logic [7:0]                    frac,
  input  wire logic                          load,
  output logic signed [smdl_pkg::SAMPLE_W-1:0] dout
);

  logic [smdl_pkg::SAMPLE_W-1:0]        mem [DELAY_DEPTH];
  logic [smdl_pkg::SAMPLE_W-1:0]        rdata;
  logic signed [smdl_pkg::SAMPLE_W-1:0] s0;
  logic signed [smdl_pkg::SAMPLE_W-1:0] s1;
  logic signed [smdl_pkg::SAMPLE_W:0]   diff;
  logic signed [33:0]                   prod;
  logic signed [33:0]                   prod_next;
  logic signed [25:0]                   y;
  logic signed [smdl_pkg::SAMPLE_W-1:0] y_sat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end else if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Entries not yet written since reset read as zero.
  assign s1        = v1 ? signed'(rdata) : '0;
  assign diff      = {s1[smdl_pkg::SAMPLE_W-1], s1} - {s0[smdl_pkg::SAMPLE_W-1], s0};
  assign prod_next = diff * signed'({1'b0, frac});
  assign y         = {{2{s0[smdl_pkg::SAMPLE_W-1]}}, s0} + prod[33:8];

  always_comb begin
    if (y[25:23] == 3'b000 || y[25:23] == 3'b111) begin
      y_sat = y[smdl_pkg::SAMPLE_W-1:0];
    end else if (y[25]) begin
      y_sat = 24'sh800000;
    end else begin
      y_sat = 24'sh7FFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_s0) begin
      s0 <= v0 ? signed'(rdata) : '0;
    end
    if (cap_s1) begin
      prod <= prod_next;
    end
    if (load) begin
      dout <= y_sat;
    end
  end

endmodule
`default_nettype wire

### hdl/smdl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo modulated delay line: datapath
// Configuration registers, write index, LFO phase, sine table, delay and read
// position arithmetic, and the two channel lanes.
// ----------------------------------------------------------------------------
module smdl_datapath #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire smdl_pkg::cmd_t                       cmd,
  input  wire logic                                 cfg_we,
  input  wire logic [smdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [smdl_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic signed [smdl_pkg::SAMPLE_W-1:0] left_in,
  input  wire logic signed [smdl_pkg::SAMPLE_W-1:0] right_in,
  output logic signed [smdl_pkg::SAMPLE_W-1:0]      left_out,
  output logic signed [smdl_pkg::SAMPLE_W-1:0]      right_out
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = $clog2(SINE_TABLE_SIZE);
  localparam int DW = AW + 8;
  localparam int RW = AW + 10;
  localparam logic signed [smdl_pkg::DCALC_W-1:0] DMIN = 26'sd256;
  localparam logic signed [smdl_pkg::DCALC_W-1:0] DMAX =
    smdl_pkg::DCALC_W'((DELAY_DEPTH - 2) * 256);
  localparam logic signed [RW-1:0] WRAP = RW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]        LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]          FULL = (AW + 1)'(DELAY_DEPTH);

  logic [smdl_pkg::CFG_W-1:0]   center_delay;
  logic [smdl_pkg::CFG_W-1:0]   depth_delay;
  logic [smdl_pkg::PHASE_W-1:0] phase_step;
  logic [AW-1:0]                write_pos;
  logic [smdl_pkg::PHASE_W-1:0] lfo_phase;
  logic [AW:0]                  fill;

  logic signed [smdl_pkg::SINE_W-1:0] sine_rom [SINE_TABLE_SIZE];
  logic [31:0]                        sidx_prod;
  logic [SW-1:0]                      sidx;
  logic signed [smdl_pkg::SINE_W-1:0] sine_q;
  logic signed [36:0]                 mprod;
  logic signed [36:0]                 mround;
  logic signed [smdl_pkg::DCALC_W-1:0] dsum;
  logic signed [smdl_pkg::DCALC_W-1:0] dclamp;
  logic [DW-1:0]                      delay_q;
  logic signed [RW-1:0]               rdiff;
  logic signed [RW-1:0]               rwrap;
  logic [AW-1:0]                      i0_next;
  logic [AW-1:0]                      i1_next;
  logic [AW-1:0]                      i0;
  logic [AW-1:0]                      i1;
  logic [7:0]                         frac;
  logic                               v0;
  logic                               v1;
  logic [AW-1:0]                      rd_addr;

  // Sine table, folded from the first quadrant at elaboration.
  for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_sine
    localparam int A4  = 4 * k;
    localparam int NEG = (A4 >= 2 * SINE_TABLE_SIZE) ? 1 : 0;
    localparam int AF  = (NEG != 0) ? A4 - 2 * SINE_TABLE_SIZE : A4;
    localparam int AQ  = (AF > SINE_TABLE_SIZE) ? 2 * SINE_TABLE_SIZE - AF : AF;
    localparam logic [63:0] XQ =
      (64'(AQ) * smdl_pkg::PI_HALF_Q30) / 64'(SINE_TABLE_SIZE);
    localparam logic [15:0] MAG = smdl_pkg::quarter_sine(XQ);
    localparam logic [15:0] VAL = (NEG != 0) ? (~MAG + 16'd1) : MAG;
    assign sine_rom[k] = signed'(VAL);
  end

  assign sidx_prod = 32'(lfo_phase) * 32'(SINE_TABLE_SIZE);
  assign sidx      = sidx_prod[16 +: SW];

  // Delay = centre + round(depth * sine / 2^15), floor on the shift.
  assign mround = mprod + 37'sd16384;
  assign dsum   = signed'({6'd0, center_delay}) + smdl_pkg::DCALC_W'(mround >>> 15);

  always_comb begin
    if (dsum < DMIN) begin
      dclamp = DMIN;
    end else if (dsum > DMAX) begin
      dclamp = DMAX;
    end else begin
      dclamp = dsum;
    end
  end

  assign rdiff   = signed'(RW'({write_pos, 8'd0})) - signed'(RW'(delay_q));
  assign rwrap   = (rdiff < 0) ? rdiff + WRAP : rdiff;
  assign i0_next = rwrap[AW+7:8];
  assign i1_next = (i0_next == LAST) ? '0 : i0_next + 1'b1;
  assign rd_addr = cmd.rd1 ? i1 : i0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_delay <= '0;
      depth_delay  <= '0;
      phase_step   <= '0;
      write_pos    <= '0;
      lfo_phase    <= '0;
      fill         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smdl_pkg::CFG_CENTER: center_delay <= cfg_data;
          smdl_pkg::CFG_DEPTH:  depth_delay  <= cfg_data;
          smdl_pkg::CFG_STEP:   phase_step   <= cfg_data[smdl_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && fill != FULL) begin
        fill <= fill + 1'b1;
      end
      if (cmd.done) begin
        write_pos <= (write_pos == LAST) ? '0 : write_pos + 1'b1;
        lfo_phase <= lfo_phase + phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sine_q <= sine_rom[sidx];
    end
    if (cmd.mul) begin
      mprod <= signed'({1'b0, depth_delay}) * sine_q;
    end
    if (cmd.dly) begin
      delay_q <= DW'(dclamp);
    end
    if (cmd.pos) begin
      i0   <= i0_next;
      i1   <= i1_next;
      frac <= rwrap[7:0];
      v0   <= ({1'b0, i0_next} < fill);
      v1   <= ({1'b0, i1_next} < fill);
    end
  end

  smdl_lane #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_left (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (write_pos),
    .wr_data (left_in),
    .rd_en   (cmd.rd0 | cmd.rd1),
    .rd_addr (rd_addr),
    .cap_s0  (cmd.rd1),
    .v0      (v0),
    .cap_s1  (cmd.intp),
    .v1      (v1),
    .frac    (frac),
    .load    (cmd.done),
    .dout    (left_out)
  );

  smdl_lane #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_right (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (write_pos),
    .wr_data (right_in),
    .rd_en   (cmd.rd0 | cmd.rd1),
    .rd_addr (rd_addr),
    .cap_s0  (cmd.rd1),
    .v0      (v0),
    .cap_s1  (cmd.intp),
    .v1      (v1),
    .frac    (frac),
    .load    (cmd.done),
    .dout    (right_out)
  );

endmodule
`default_nettype wire

### hdl/stereo_modulated_delay_line_core.sv
`default_nettype none
// A result is valid after its request passes the multiply, delay, position, two
// read, interpolation and output states; a new request waits until it is done,
// set by the single-port store of each channel (one write, two reads each).
// Reset (synchronous): clears control, write index, LFO phase, fill count and the
// configuration registers. Store contents are not cleared; entries not yet
// written read as zero through the fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Stereo modulated delay line: top level
// Sine-swept fractional delay on a stereo sample stream, linear interpolation.
// ----------------------------------------------------------------------------
module stereo_modulated_delay_line_core #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [smdl_pkg::SAMPLE_W-1:0] left_in,
  input  wire logic signed [smdl_pkg::SAMPLE_W-1:0] right_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [smdl_pkg::SAMPLE_W-1:0]      left_out,
  output logic signed [smdl_pkg::SAMPLE_W-1:0]      right_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [smdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [smdl_pkg::CFG_W-1:0]           cfg_data
);

  smdl_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  smdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  smdl_datapath #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .left_in   (left_in),
    .right_in  (right_in),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule
`default_nettype wire

### hdl/smdl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo modulated delay line: port checker
// Watches the top level's handshakes and is bound to every instance of it.
// ----------------------------------------------------------------------------
module smdl_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic signed [smdl_pkg::SAMPLE_W-1:0] left_out,
  input wire logic signed [smdl_pkg::SAMPLE_W-1:0] right_out
);

  // A result held under stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("result changed while stalled");

  // After a request is taken the block is busy and stalls further requests.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("request accepted too soon after the previous one");

  // A new result only appears at the end of a busy period.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // When the block becomes free again, its result is on offer.
  a_free: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid)
    else $error("block freed without presenting a result");

endmodule

bind stereo_modulated_delay_line_core smdl_checker u_smdl_checker (.*);
`default_nettype wire
